// ===== rtl/uwt_pkg.sv =====
package uwt_pkg;

    localparam int COUNT_BITS = 12;
    localparam int CHARS_BITS = 12;
    localparam int PEND_BITS  = 6;
    localparam int CMP_BITS   = (COUNT_BITS > CHARS_BITS ? COUNT_BITS : CHARS_BITS) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [PEND_BITS-1:0]  PEND_MAX  = {PEND_BITS{1'b1}};
    localparam logic [CHARS_BITS-1:0] MAX_CHARS_RESET = 12'd80;

    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_SP  = 8'h20;

    localparam logic [1:0] LEAD_TOP     = 2'b11;
    localparam logic [3:0] LEAD_FOUR    = 4'b1111;
    localparam logic [3:0] LEAD_THREE   = 4'b1110;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  byte_valid;
        logic                  word_end;
        logic                  at_line_end;
        logic                  at_stream_end;
        logic [CHARS_BITS-1:0] word_chars;
    } result_t;

    // Continuation bytes a lead byte announces.
    function automatic logic [1:0] lead_extra(input logic [7:0] b);
        logic [1:0] extra;
        extra = 2'd0;
        if (b[7:6] == LEAD_TOP)
        begin
            if (b[7:4] == LEAD_FOUR)
                extra = 2'd3;
            else if (b[7:4] == LEAD_THREE)
                extra = 2'd2;
            else
                extra = 2'd1;
        end
        return extra;
    endfunction

endpackage

// ===== rtl/utf8_word_tokenizer.sv =====
// A word result is registered in the output stage, or in the skid stage while the output stalls.
// Throughput: one byte per cycle while the skid stage is empty; the per-byte decode and counters sit between
// the input handshake and the result register, with a one-entry skid stage behind it.
// Reset (rst_n low, asynchronous): counters cleared, character limit back to 80,
// result and skid stages emptied.
module utf8_word_tokenizer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [uwt_pkg::CHARS_BITS-1:0] cfg_data,
    input  logic            item_valid,
    output logic            item_stall,
    input  uwt_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output uwt_pkg::result_t result
);
    import uwt_pkg::*;

    logic [CHARS_BITS-1:0] char_limit_reg;
    logic [COUNT_BITS-1:0] chars_reg, chars_next;
    logic [PEND_BITS-1:0]  pend_reg, pend_next;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic    accept;
    logic    pop;
    logic    res_valid;
    result_t res;

    logic [PEND_BITS:0]    pend_sum;
    logic [PEND_BITS-1:0]  pend_sat;
    logic [COUNT_BITS-1:0] chars_inc;
    logic                  at_limit;
    logic [CHARS_BITS-1:0] chars_out;

    assign cfg_ready    = 1'b1;
    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !item_stall;
    assign pop          = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign pend_sum  = {1'b0, pend_reg} + (PEND_BITS+1)'(lead_extra(item.byte_value));
    assign pend_sat  = pend_sum[PEND_BITS] ? PEND_MAX : pend_sum[PEND_BITS-1:0];
    assign chars_inc = (chars_reg < COUNT_MAX) ? chars_reg + 1'b1 : chars_reg;
    assign at_limit  = (CMP_BITS'(chars_inc) >= CMP_BITS'(char_limit_reg))
                    || (chars_inc == COUNT_MAX);
    assign chars_out = CHARS_BITS'(chars_reg);

    always_comb
    begin
        res        = '0;
        res_valid  = 1'b0;
        chars_next = chars_reg;
        pend_next  = pend_reg;
        if (item.end_of_input)
        begin
            res_valid         = 1'b1;
            res.word_end      = 1'b1;
            res.at_stream_end = 1'b1;
            res.word_chars    = chars_out;
            chars_next        = '0;
            pend_next         = '0;
        end
        else if (item.byte_value == BYTE_LF)
        begin
            res_valid       = 1'b1;
            res.word_end    = 1'b1;
            res.at_line_end = 1'b1;
            res.word_chars  = chars_out;
            chars_next      = '0;
            pend_next       = '0;
        end
        else if (item.byte_value == BYTE_SP || item.byte_value == BYTE_TAB)
        begin
            // skip leading blanks and blanks inside an unfinished first character
            if (chars_reg != '0)
            begin
                res_valid      = 1'b1;
                res.word_end   = 1'b1;
                res.word_chars = chars_out;
                chars_next     = '0;
                pend_next      = '0;
            end
        end
        else if (item.byte_value != BYTE_CR)
        begin
            res_valid      = 1'b1;
            res.out_byte   = item.byte_value;
            res.byte_valid = 1'b1;
            if (pend_sat != '0)
            begin
                pend_next = pend_sat - 1'b1;
            end
            else if (at_limit)
            begin
                res.word_end   = 1'b1;
                res.word_chars = CHARS_BITS'(chars_inc);
                chars_next     = '0;
                pend_next      = '0;
            end
            else
            begin
                chars_next = chars_inc;
                pend_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_limit_reg <= MAX_CHARS_RESET;
            chars_reg      <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                char_limit_reg <= cfg_data;
            if (accept)
            begin
                chars_reg <= chars_next;
                pend_reg  <= pend_next;
            end
        end
    end

    // Output register with a one-entry skid behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= accept && res_valid;
        end
        else if (accept && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || pop)
        begin
            out_reg <= res;
        end
        else if (accept && res_valid)
        begin
            skid_reg <= res;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while the output stage is empty");

    a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !pop) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid word changed or was lost while the output stalled");

    a_chars_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.word_end) |->
            (out_reg.word_chars == '0 && !out_reg.at_line_end && !out_reg.at_stream_end))
        else $error("end fields set on a word byte that does not end the word");

    a_byte_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.byte_valid) |-> (out_reg.out_byte == '0))
        else $error("byte field nonzero without byte_valid");

    a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        chars_reg != COUNT_MAX)
        else $error("character count sits at its maximum between words");

endmodule
